FILE: rtl/sswf_pkg.sv
package sswf_pkg;

    localparam int COMP_W     = 16;
    localparam int SQ_W       = 31;
    localparam int MAG_W      = 32;
    localparam int FRAC_W     = 16;
    localparam int OUT_W      = 12;
    localparam int IN_TDATA_W = 6 * COMP_W;
    localparam int OUT_TDATA_W = 16;
    localparam int N_COMP     = 6;

    localparam logic [FRAC_W-1:0] THR_RESET = 16'd33;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;
    localparam int Q_CW    = 3;

    typedef struct packed {
        logic [MAG_W-1:0] mag;
        logic             last;
    } t_mag_item;

    typedef enum logic [2:0] {
        BK_LOAD,
        BK_MUL1,
        BK_MUL2,
        BK_POS,
        BK_NEG,
        BK_FIN,
        BK_OUT
    } t_back_state;

endpackage

FILE: rtl/sswf_front.sv
module sswf_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [sswf_pkg::IN_TDATA_W-1:0] i_data,
    input  logic                            i_last,
    output logic                            o_item_valid,
    input  logic                            i_item_ready,
    output sswf_pkg::t_mag_item             o_item
);
    import sswf_pkg::*;

    logic                    r_v1, r_v2, r_v3;
    logic                    r_last1, r_last2, r_last3;
    logic [SQ_W-1:0]         r_sq [N_COMP];
    logic [MAG_W-1:0]        r_sum [3];
    logic [MAG_W-1:0]        r_mag;
    logic                    adv1, adv2, adv3;
    logic signed [2*COMP_W-1:0] sq_full [N_COMP];
    logic [MAG_W-1:0]        mag_max;

    assign adv3    = !r_v3 || i_item_ready;
    assign adv2    = !r_v2 || adv3;
    assign adv1    = !r_v1 || adv2;
    assign o_ready = adv1;

    always_comb begin
        for (int i = 0; i < N_COMP; i++) begin
            sq_full[i] = $signed(i_data[i*COMP_W +: COMP_W])
                       * $signed(i_data[i*COMP_W +: COMP_W]);
        end
    end

    // largest of the three component squared magnitudes
    always_comb begin
        mag_max = r_sum[0];
        if (r_sum[1] > mag_max) begin
            mag_max = r_sum[1];
        end
        if (r_sum[2] > mag_max) begin
            mag_max = r_sum[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (adv1) begin
                r_v1 <= i_valid;
            end
            if (adv2) begin
                r_v2 <= r_v1;
            end
            if (adv3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_last1 <= i_last;
            for (int i = 0; i < N_COMP; i++) begin
                r_sq[i] <= sq_full[i][SQ_W-1:0];
            end
        end
        if (adv2) begin
            r_last2 <= r_last1;
            for (int c = 0; c < 3; c++) begin
                r_sum[c] <= MAG_W'(r_sq[2*c]) + MAG_W'(r_sq[2*c+1]);
            end
        end
        if (adv3) begin
            r_last3 <= r_last2;
            r_mag   <= mag_max;
        end
    end

    assign o_item_valid = r_v3;
    assign o_item.mag   = r_mag;
    assign o_item.last  = r_last3;

endmodule

FILE: rtl/sswf_queue.sv
module sswf_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push_valid,
    output logic                o_push_ready,
    input  sswf_pkg::t_mag_item i_push_item,
    output logic                o_pop_valid,
    input  logic                i_pop_ready,
    output sswf_pkg::t_mag_item o_pop_item
);
    import sswf_pkg::*;

    t_mag_item         r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [Q_CW-1:0]   r_cnt;
    logic              push, pop;

    assign o_push_ready = (r_cnt != Q_CW'(Q_DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;
    assign o_pop_item   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

endmodule

FILE: rtl/sswf_back.sv
module sswf_back #(
    parameter int MAX_POINTS = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [sswf_pkg::FRAC_W-1:0]   i_thr,
    input  logic                          i_item_valid,
    output logic                          o_item_ready,
    input  sswf_pkg::t_mag_item           i_item,
    output logic                          o_res_valid,
    input  logic                          i_res_ready,
    output logic [sswf_pkg::OUT_W-1:0]    o_res
);
    import sswf_pkg::*;

    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int AW = $clog2(MAX_POINTS);

    logic [MAG_W-1:0] r_store [MAX_POINTS];

    t_back_state      r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic [MAG_W-1:0] r_peak, n_peak;
    logic [CW-1:0]    r_n, n_n;
    logic [MAG_W-1:0] r_fsq, n_fsq;
    logic [MAG_W-1:0] r_lim_hi, n_lim_hi;
    logic [CW-1:0]    r_k, n_k;
    logic             r_iss, n_iss;
    logic             r_chk_v, n_chk_v;
    logic [CW-1:0]    r_chk_idx, n_chk_idx;
    logic [CW-1:0]    r_npos, n_npos;
    logic [CW-1:0]    r_nneg, n_nneg;
    logic [CW-1:0]    r_res, n_res;
    logic [MAG_W-1:0] r_rd_data;

    logic             mem_we;
    logic             rd_en;
    logic [CW-1:0]    half;
    logic [CW-1:0]    width_neg;
    logic             hit;
    logic [2*MAG_W-1:0] lim_full;
    logic [CW+OUT_W-1:0] res_ext;

    assign half      = r_n >> 1;
    assign width_neg = r_n - r_nneg;
    assign hit       = r_chk_v && (r_rd_data > r_lim_hi);
    // store * 2^32 > limit reduces to a compare against the upper word
    assign lim_full  = {{MAG_W{1'b0}}, r_fsq} * {{MAG_W{1'b0}}, r_peak};
    assign res_ext   = {{OUT_W{1'b0}}, r_res};
    assign o_res     = res_ext[OUT_W-1:0];

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_peak    = r_peak;
        n_n       = r_n;
        n_fsq     = r_fsq;
        n_lim_hi  = r_lim_hi;
        n_k       = r_k;
        n_iss     = r_iss;
        n_chk_v   = r_chk_v;
        n_chk_idx = r_chk_idx;
        n_npos    = r_npos;
        n_nneg    = r_nneg;
        n_res     = r_res;
        mem_we       = 1'b0;
        rd_en        = 1'b0;
        o_item_ready = 1'b0;
        o_res_valid  = 1'b0;
        case (r_state)
            BK_LOAD: begin
                o_item_ready = 1'b1;
                if (i_item_valid) begin
                    if (r_count < CW'(MAX_POINTS)) begin
                        mem_we  = 1'b1;
                        n_count = r_count + 1'b1;
                        if (i_item.mag > r_peak) begin
                            n_peak = i_item.mag;
                        end
                    end
                    if (i_item.last) begin
                        n_n     = n_count;
                        n_state = BK_MUL1;
                    end
                end
            end
            BK_MUL1: begin
                n_fsq   = MAG_W'(i_thr) * MAG_W'(i_thr);
                n_npos  = (half != '0) ? half - 1'b1 : '0;
                n_nneg  = half;
                n_state = BK_MUL2;
            end
            BK_MUL2: begin
                n_lim_hi = lim_full[2*MAG_W-1:MAG_W];
                n_k      = half - 1'b1;
                n_iss    = (half >= CW'(2));
                n_chk_v  = 1'b0;
                n_state  = BK_POS;
            end
            BK_POS: begin
                // downward scan over the positive half, one read per cycle
                if (hit) begin
                    n_npos = r_chk_idx;
                end
                if (hit || (!r_iss && !r_chk_v)) begin
                    n_k     = half;
                    n_iss   = (half < r_n);
                    n_chk_v = 1'b0;
                    n_state = BK_NEG;
                end else begin
                    n_chk_v   = r_iss;
                    n_chk_idx = r_k;
                    if (r_iss) begin
                        rd_en = 1'b1;
                        if (r_k == CW'(1)) begin
                            n_iss = 1'b0;
                        end else begin
                            n_k = r_k - 1'b1;
                        end
                    end
                end
            end
            BK_NEG: begin
                if (hit) begin
                    n_nneg = r_chk_idx;
                end
                if (hit || (!r_iss && !r_chk_v)) begin
                    n_chk_v = 1'b0;
                    n_state = BK_FIN;
                end else begin
                    n_chk_v   = r_iss;
                    n_chk_idx = r_k;
                    if (r_iss) begin
                        rd_en = 1'b1;
                        if (r_k == r_n - 1'b1) begin
                            n_iss = 1'b0;
                        end else begin
                            n_k = r_k + 1'b1;
                        end
                    end
                end
            end
            BK_FIN: begin
                n_res   = (r_npos > width_neg) ? r_npos : width_neg;
                n_state = BK_OUT;
            end
            BK_OUT: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_count = '0;
                    n_peak  = '0;
                    n_state = BK_LOAD;
                end
            end
            default: begin
                n_state = BK_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_LOAD;
            r_count <= '0;
            r_peak  <= '0;
            r_iss   <= 1'b0;
            r_chk_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_peak  <= n_peak;
            r_iss   <= n_iss;
            r_chk_v <= n_chk_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n       <= n_n;
        r_fsq     <= n_fsq;
        r_lim_hi  <= n_lim_hi;
        r_k       <= n_k;
        r_chk_idx <= n_chk_idx;
        r_npos    <= n_npos;
        r_nneg    <= n_nneg;
        r_res     <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_store[r_count[AW-1:0]] <= i_item.mag;
        end
        if (rd_en) begin
            r_rd_data <= r_store[r_k[AW-1:0]];
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_POINTS))
        else $error("point count beyond store depth");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_POS && r_chk_v) |-> (r_chk_idx != '0 && r_chk_idx < half))
        else $error("positive scan index out of range");

    a_neg_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_NEG && r_chk_v) |-> (r_chk_idx >= half && r_chk_idx < r_n))
        else $error("negative scan index out of range");

    a_res_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_OUT) |-> (r_res >= r_npos && r_res <= r_n))
        else $error("result outside npos..count");

endmodule

FILE: rtl/spectrum_support_width_finder.sv
// channel   | direction | tdata (low bit up)                             | tuser/tlast
// s_axis    | in        | x_real, x_imag, y_real, y_imag, z_real, z_imag | tlast = last_point
// m_axis    | out       | support_half_width, zero fill to 16 bits       | none
// i_cfg_*   | in        | threshold_fraction                             | none
//
// points are taken one per cycle while loading; a 3-stage magnitude pipeline and a
// 4-entry queue feed the store, so input keeps flowing while a scan runs until they fill
// after the last point the back end squares the threshold, forms the limit, scans
// the positive then the negative half through the single read port of the magnitude
// store and picks the wider side, offers the request, then holds it until taken
// no clearing pass: only entries written for the current spectrum are ever read
// reset is synchronous, active low; the threshold returns to 33
module spectrum_support_width_finder #(
    parameter int MAX_POINTS = 4096
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [sswf_pkg::FRAC_W-1:0]      i_cfg_wdata,   // threshold_fraction
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // x_real, x_imag, y_real, y_imag, z_real, z_imag
    input  logic [sswf_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                             s_axis_tlast,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // support_half_width, zero fill
    output logic [sswf_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import sswf_pkg::*;

    logic [FRAC_W-1:0] r_thr;
    logic              f_valid, f_ready;
    t_mag_item         f_item;
    logic              q_valid, q_ready;
    t_mag_item         q_item;
    logic [OUT_W-1:0]  res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_wdata;
        end
    end

    sswf_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_data       (s_axis_tdata),
        .i_last       (s_axis_tlast),
        .o_item_valid (f_valid),
        .i_item_ready (f_ready),
        .o_item       (f_item)
    );

    sswf_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_valid),
        .o_push_ready (f_ready),
        .i_push_item  (f_item),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready),
        .o_pop_item   (q_item)
    );

    sswf_back #(
        .MAX_POINTS (MAX_POINTS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_thr        (r_thr),
        .i_item_valid (q_valid),
        .o_item_ready (q_ready),
        .i_item       (q_item),
        .o_res_valid  (m_axis_tvalid),
        .i_res_ready  (m_axis_tready),
        .o_res        (res)
    );

    assign m_axis_tdata = {{(OUT_TDATA_W - OUT_W){1'b0}}, res};

endmodule
